// ===== hdl/wrm_pkg.sv =====
// shared types and constants for the watchpoint range matcher
// item kind codes, watch type codes and the decoded command passed front to back
`timescale 1ns / 1ps
`default_nettype none

package wrm_pkg;

  localparam int ADDR_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // user-break trap event code
  localparam logic [8:0] USER_BREAK_EVENT = 9'h1E0;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] TYPE_READ   = 2'd0;
  localparam logic [1:0] TYPE_WRITE  = 2'd1;
  localparam logic [1:0] TYPE_ACCESS = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REMOVE,
    OP_ACCESS,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [1:0]        watch_type;
    logic [1:0]        want_type;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] byte_length;
    logic [ADDR_W-1:0] end_address;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/wrm_front.sv =====
// front end: decodes the item kind and precomputes the range end
// depends on wrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wrm_front
  import wrm_pkg::*;
(
  input  wire logic              in_valid,
  input  wire logic [2:0]        kind,
  input  wire logic [1:0]        watch_type,
  input  wire logic [ADDR_W-1:0] start_address,
  input  wire logic [ADDR_W-1:0] byte_length,
  input  wire logic              queue_full,
  output logic                   in_stall,
  output logic                   push,
  output cmd_t                   cmd
);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    cmd.watch_type    = watch_type;
    cmd.start_address = start_address;
    cmd.byte_length   = byte_length;
    cmd.end_address   = start_address + byte_length;
    cmd.want_type     = TYPE_READ;
    case (kind)
      KIND_ADD: begin
        cmd.op = OP_ADD;
      end
      KIND_REMOVE: begin
        cmd.op = OP_REMOVE;
      end
      KIND_READ: begin
        cmd.op = OP_ACCESS;
      end
      KIND_WRITE: begin
        cmd.op        = OP_ACCESS;
        cmd.want_type = TYPE_WRITE;
      end
      KIND_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/wrm_queue.sv =====
// short command queue between front and back ends
// depends on wrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wrm_queue
  import wrm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wrm_back.sv =====
// back end: slot table with parallel per-slot comparators and result register
// depends on wrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wrm_back
  import wrm_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire cmd_t              head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   success,
  output logic                   table_full,
  output logic                   trap_hit,
  output logic [ADDR_W-1:0]      last_hit_address,
  output logic                   any_active
);

  logic [SLOT_COUNT-1:0] slot_valid;
  logic [1:0]            slot_type    [SLOT_COUNT];
  logic [ADDR_W-1:0]     slot_address [SLOT_COUNT];
  logic [ADDR_W-1:0]     slot_length  [SLOT_COUNT];
  logic [ADDR_W-1:0]     slot_end     [SLOT_COUNT];
  logic [ADDR_W-1:0]     hit_address;

  logic [SLOT_COUNT-1:0] same_vec;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] free_onehot;
  logic [SLOT_COUNT-1:0] slot_valid_next;
  logic [ADDR_W-1:0]     hit_address_next;
  logic                  dup;
  logic                  has_free;
  logic                  any_hit;
  logic                  do_insert;
  logic                  success_next;
  logic                  table_full_next;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      same_vec[i] = slot_valid[i]
                    && (slot_type[i] == head_cmd.watch_type)
                    && (slot_address[i] == head_cmd.start_address)
                    && (slot_length[i] == head_cmd.byte_length);
      hit_vec[i]  = slot_valid[i]
                    && ((slot_type[i] == head_cmd.want_type) || (slot_type[i] == TYPE_ACCESS))
                    && (head_cmd.start_address < slot_end[i])
                    && (slot_address[i] < head_cmd.end_address);
    end
  end

  // lowest free slot as a one-hot vector
  assign free_vec    = ~slot_valid;
  assign free_onehot = free_vec & (~free_vec + SLOT_COUNT'(1));
  assign dup         = |same_vec;
  assign has_free    = |free_vec;
  assign any_hit     = |hit_vec;
  assign do_insert   = pop && (head_cmd.op == OP_ADD) && !dup && has_free;

  always_comb begin
    slot_valid_next  = slot_valid;
    hit_address_next = hit_address;
    success_next     = 1'b0;
    table_full_next  = 1'b0;
    case (head_cmd.op)
      OP_ADD: begin
        if (dup) begin
          success_next = 1'b1;
        end else if (has_free) begin
          slot_valid_next = slot_valid | free_onehot;
          success_next    = 1'b1;
        end else begin
          table_full_next = 1'b1;
        end
      end
      OP_REMOVE: begin
        slot_valid_next = slot_valid & ~same_vec;
        success_next    = dup;
      end
      OP_ACCESS: begin
        if (any_hit) begin
          hit_address_next = head_cmd.start_address;
        end
      end
      OP_CLEAR: begin
        slot_valid_next  = '0;
        hit_address_next = '0;
      end
      default: begin
        slot_valid_next = slot_valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (do_insert && free_onehot[i]) begin
        slot_type[i]    <= head_cmd.watch_type;
        slot_address[i] <= head_cmd.start_address;
        slot_length[i]  <= head_cmd.byte_length;
        slot_end[i]     <= head_cmd.end_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      success          <= success_next;
      table_full       <= table_full_next;
      trap_hit         <= (head_cmd.op == OP_ACCESS) && any_hit;
      last_hit_address <= hit_address_next;
      any_active       <= |slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      hit_address <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        slot_valid  <= slot_valid_next;
        hit_address <= hit_address_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/watchpoint_range_matcher.sv =====
// watchpoint range matcher top level: front decode, command queue, slot table back end
// an accepted transaction is queued, then popped by the back end, which registers the result
// throughput: one transaction per cycle when not stalled; back end checks all slots at once
// reset: synchronous; empties the queue, invalidates every slot and zeroes the hit address
`timescale 1ns / 1ps
`default_nettype none

module watchpoint_range_matcher
  import wrm_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        kind,
  input  wire logic [1:0]        watch_type,
  input  wire logic [ADDR_W-1:0] start_address,
  input  wire logic [ADDR_W-1:0] byte_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   success,
  output logic                   table_full,
  output logic                   trap_hit,
  output logic [ADDR_W-1:0]      last_hit_address,
  output logic                   any_active
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;

  wrm_front u_front (
    .in_valid      (in_valid),
    .kind          (kind),
    .watch_type    (watch_type),
    .start_address (start_address),
    .byte_length   (byte_length),
    .queue_full    (queue_full),
    .in_stall      (in_stall),
    .push          (push),
    .cmd           (front_cmd)
  );

  wrm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wrm_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .success          (success),
    .table_full       (table_full),
    .trap_hit         (trap_hit),
    .last_hit_address (last_hit_address),
    .any_active       (any_active)
  );

`ifndef SYNTHESIS
  // a refused add always means the table holds entries
  assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> any_active && !success)
    else $error("table_full reported with empty table or success");

  // a trap only comes from an access, never from add or remove
  assert property (@(posedge clk) disable iff (rst)
    out_valid && trap_hit |-> !success && !table_full)
    else $error("trap_hit together with add/remove flags");

  // the back end only pops a queued transaction
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== dv/wrm_scoreboard_pkg.sv =====
// scoreboard for the watchpoint range matcher testbench
// predicts the watch table and trap results from accepted transactions; needs wrm_pkg
`timescale 1ns / 1ps

package wrm_scoreboard_pkg;
  import wrm_pkg::*;

  class watch_scoreboard;
    localparam int SLOTS = 16;

    typedef struct packed {
      logic        success;
      logic        table_full;
      logic        trap_hit;
      logic [31:0] hit_addr;
      logic        active;
    } outcome_t;

    logic [SLOTS-1:0] slot_used;
    logic [1:0]       slot_type [SLOTS];
    logic [31:0]      slot_base [SLOTS];
    logic [31:0]      slot_len  [SLOTS];
    logic [31:0]      hit_addr;
    outcome_t         expected_q [$];
    int               errors;

    function new();
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      slot_used = '0;
      hit_addr  = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_type[i] = '0;
        slot_base[i] = '0;
        slot_len[i]  = '0;
      end
    endfunction

    // both ends wrap modulo 2^32
    function bit ranges_overlap(logic [31:0] a_start, logic [31:0] a_len,
                                logic [31:0] b_start, logic [31:0] b_len);
      logic [31:0] a_end;
      logic [31:0] b_end;
      a_end = a_start + a_len;
      b_end = b_start + b_len;
      return (a_start < b_end) && (b_start < a_end);
    endfunction

    function int find_entry(logic [1:0] wtype, logic [31:0] addr, logic [31:0] len);
      int idx;
      idx = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (slot_used[i] && slot_type[i] == wtype && slot_base[i] == addr && slot_len[i] == len)
          idx = i;
      return idx;
    endfunction

    function void note_input(logic [2:0] kind, logic [1:0] wtype,
                             logic [31:0] addr, logic [31:0] len);
      outcome_t   o;
      int         idx;
      logic [1:0] want;
      o = '0;
      case (kind)
        KIND_ADD: begin
          if (find_entry(wtype, addr, len) >= 0) begin
            o.success = 1'b1;
          end else begin
            idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
              if (!slot_used[i]) idx = i;
            if (idx >= 0) begin
              slot_used[idx] = 1'b1;
              slot_type[idx] = wtype;
              slot_base[idx] = addr;
              slot_len[idx]  = len;
              o.success = 1'b1;
            end else begin
              o.table_full = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          idx = find_entry(wtype, addr, len);
          if (idx >= 0) begin
            slot_used[idx] = 1'b0;
            o.success = 1'b1;
          end
        end
        KIND_READ, KIND_WRITE: begin
          want = (kind == KIND_READ) ? TYPE_READ : TYPE_WRITE;
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (slot_type[i] == want || slot_type[i] == TYPE_ACCESS) &&
                ranges_overlap(addr, len, slot_base[i], slot_len[i]))
              o.trap_hit = 1'b1;
          if (o.trap_hit) hit_addr = addr;
        end
        KIND_CLEAR: clear_table();
        default: ;
      endcase
      o.hit_addr = hit_addr;
      o.active   = |slot_used;
      expected_q.insert(expected_q.size(), o);
    endfunction

    // random occupied slot, or -1 when the table is empty
    function int pick_slot();
      int used_q [$];
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i]) used_q.insert(used_q.size(), i);
      if (used_q.size() == 0) return -1;
      return used_q[$urandom_range(0, used_q.size() - 1)];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      errors++;
    endtask

    task check_result(logic s, logic f, logic t, logic [31:0] h, logic act);
      outcome_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", {31'b0, s}, '0);
        return;
      end
      want = expected_q.pop_front();
      if (s !== want.success) report("success", {31'b0, s}, {31'b0, want.success});
      if (f !== want.table_full) report("table_full", {31'b0, f}, {31'b0, want.table_full});
      if (t !== want.trap_hit) report("trap_hit", {31'b0, t}, {31'b0, want.trap_hit});
      if (h !== want.hit_addr) report("last_hit_address", h, want.hit_addr);
      if (act !== want.active) report("any_active", {31'b0, act}, {31'b0, want.active});
    endtask
  endclass

endpackage

// ===== dv/tb_watchpoint_range_matcher.sv =====
// testbench top for watchpoint_range_matcher: directed and random add, remove, access,
// clear and reserved-kind transactions with random stalls; needs wrm_pkg, wrm_scoreboard_pkg
`timescale 1ns / 1ps

module tb_watchpoint_range_matcher;
  import wrm_pkg::*;
  import wrm_scoreboard_pkg::*;

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
  localparam logic [1:0] TYPE_UNDEF      = 2'd3;
  localparam int         HOLD_CYCLES     = 60;
  localparam int         STALL_LIMIT     = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [1:0]  watch_type = '0;
  logic [31:0] start_address = '0;
  logic [31:0] byte_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        success;
  logic        table_full;
  logic        trap_hit;
  logic [31:0] last_hit_address;
  logic        any_active;

  watch_scoreboard sb;
  int unsigned     idle_odds = 4;
  bit              hold_req = 1'b0;
  int              quiet_cycles = 0;

  watchpoint_range_matcher DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind             (kind),
    .watch_type       (watch_type),
    .start_address    (start_address),
    .byte_length      (byte_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .success          (success),
    .table_full       (table_full),
    .trap_hit         (trap_hit),
    .last_hit_address (last_hit_address),
    .any_active       (any_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_input(kind, watch_type, start_address, byte_length);
      if (out_valid && !out_stall)
        sb.check_result(success, table_full, trap_hit, last_hit_address, any_active);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_watchpoint_range_matcher: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic [2:0] k, logic [1:0] t, logic [31:0] a, logic [31:0] l);
    if (idle_odds != 0 && !hold_req && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    watch_type    <= t;
    start_address <= a;
    byte_length   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'hFFFF_FFC0 + 32'($urandom_range(0, 63));
      2: return 32'($urandom_range(0, 255));
      default: return 32'h0000_1000 * 32'($urandom_range(1, 4)) + 32'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 7))
      0: return '0;
      6: return $urandom;
      7: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return 32'($urandom_range(1, 64));
    endcase
  endfunction

  // add_pct sets how fast the table fills; removes 15%, accesses the rest below 94%
  task automatic random_item(int unsigned add_pct);
    logic [2:0]  k;
    logic [1:0]  t;
    logic [31:0] a;
    logic [31:0] l;
    int unsigned r;
    int          idx;
    r = $urandom_range(0, 99);
    t = ($urandom_range(0, 9) == 0) ? TYPE_UNDEF : 2'($urandom_range(0, 2));
    a = pick_address();
    l = pick_length();
    idx = sb.pick_slot();
    if (r < add_pct) begin
      k = KIND_ADD;
      if (idx >= 0 && $urandom_range(0, 9) == 0) begin
        t = sb.slot_type[idx];
        a = sb.slot_base[idx];
        l = sb.slot_len[idx];
      end
    end else if (r < add_pct + 15) begin
      k = KIND_REMOVE;
      if (idx >= 0 && $urandom_range(0, 3) != 0) begin
        t = sb.slot_type[idx];
        a = sb.slot_base[idx];
        l = sb.slot_len[idx];
      end
    end else if (r < 94) begin
      k = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
      t = 2'($urandom_range(0, 3));
      if (idx >= 0 && $urandom_range(0, 2) != 0) begin
        a = sb.slot_base[idx] - 32'd16 + 32'($urandom_range(0, 32));
        l = 32'($urandom_range(0, 24));
      end
    end else if (r < 97) begin
      k = KIND_CLEAR;
    end else begin
      k = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    end
    send(k, t, a, l);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    send(KIND_READ,   TYPE_READ,   32'h0000_0000, 32'h4);
    send(KIND_ADD,    TYPE_READ,   32'h0000_1000, 32'h10);
    send(KIND_ADD,    TYPE_READ,   32'h0000_1000, 32'h10);
    send(KIND_READ,   TYPE_ACCESS, 32'h0000_100F, 32'h1);
    send(KIND_READ,   TYPE_READ,   32'h0000_1010, 32'h4);
    send(KIND_WRITE,  TYPE_WRITE,  32'h0000_1000, 32'h4);
    send(KIND_ADD,    TYPE_WRITE,  32'hFFFF_FFF0, 32'h20);
    send(KIND_WRITE,  TYPE_READ,   32'hFFFF_FFF8, 32'h4);
    send(KIND_WRITE,  TYPE_READ,   32'h0000_0004, 32'h4);
    send(KIND_ADD,    TYPE_ACCESS, 32'h8000_0000, 32'h0);
    send(KIND_WRITE,  TYPE_READ,   32'h7FFF_FFFF, 32'h2);
    send(KIND_READ,   TYPE_READ,   32'h8000_0000, 32'h0);
    send(KIND_ADD,    TYPE_UNDEF,  32'h0000_2000, 32'h100);
    send(KIND_READ,   TYPE_READ,   32'h0000_2000, 32'h4);
    send(KIND_WRITE,  TYPE_WRITE,  32'h0000_2000, 32'h4);
    send(KIND_REMOVE, TYPE_UNDEF,  32'h0000_2000, 32'h100);
    send(KIND_REMOVE, TYPE_UNDEF,  32'h0000_2000, 32'h100);
    send(KIND_ADD,    TYPE_READ,   32'h0000_0000, 32'h0);
    send(KIND_ADD,    TYPE_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
      send(3'(k), TYPE_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_CLEAR,  TYPE_UNDEF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_READ,   TYPE_READ,   32'h0000_1000, 32'h10);

    repeat (150) random_item(30);

    // long receiver hold-off while transactions keep coming
    hold_req = 1'b1;
    repeat (25) random_item(30);
    drain();

    idle_odds = 6;
    repeat (150) random_item(60);
    drain();

    idle_odds = 2;
    repeat (150) random_item(40);

    idle_odds = 0;
    repeat (150) random_item(30);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_watchpoint_range_matcher: clean");
    else
      $display("tb_watchpoint_range_matcher: errors");
    $finish;
  end

endmodule
